// ===== sv/clut_texel_fetch_decode_unit_macros.svh =====
// assertion macros shared by the texel fetch block
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef CLUT_TEXEL_FETCH_DECODE_UNIT_MACROS_SVH
`define CLUT_TEXEL_FETCH_DECODE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked outside reset only
`define CTFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define CTFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define CTFD_ASSERT(label, prop, msg)
`define CTFD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== sv/ctfd_pkg.sv =====
// shared widths, codes and controller/datapath types of the texel fetch block
// no dependencies
package ctfd_pkg;

  localparam int ReqXW    = 10;
  localparam int ReqYW    = 9;
  localparam int HalfW    = 16;
  localparam int TexW     = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_PAGE_X     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_Y     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_MODE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLUT_X     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CLUT_Y     = 3'd4;

  localparam logic [1:0] MODE_CLUT4      = 2'd0;
  localparam logic [1:0] MODE_CLUT8      = 2'd1;
  localparam logic [1:0] MODE_DIRECT     = 2'd2;
  localparam logic [1:0] MODE_DIRECT_ALT = 2'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic latch_item;
    logic clear_write;
    logic mem_write;
    logic tex_read;
    logic clut_read;
    logic load_out;
  } ctfd_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_fetch;
    logic is_direct;
  } ctfd_sts_t;

endpackage

// ===== sv/ctfd_if.sv =====
// request, result and configuration channels of the texel fetch block
// depends on ctfd_pkg
interface ctfd_req_if;
  import ctfd_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ReqXW-1:0]  vram_x;
  logic [ReqYW-1:0]  vram_y;
  logic [HalfW-1:0]  write_data;
  logic [TexW-1:0]   tex_u;
  logic [TexW-1:0]   tex_v;
  modport source (output valid, req_type, vram_x, vram_y, write_data, tex_u, tex_v,
                  input ready);
  modport sink (input valid, req_type, vram_x, vram_y, write_data, tex_u, tex_v,
                output ready);
endinterface

interface ctfd_res_if;
  import ctfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] texel_raw;
  logic [HalfW-1:0] texel_rgba;
  modport source (output valid, texel_raw, texel_rgba, input ready);
  modport sink (input valid, texel_raw, texel_rgba, output ready);
endinterface

interface ctfd_cfg_if;
  import ctfd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/clut_texel_fetch_decode_unit.sv =====
// Texture-page texel fetch with palette lookup over a halfword video memory.
//
// req_i takes two kinds of item. A write stores write_data at (vram_x, vram_y)
// and gives no result. A fetch reads texel (tex_u, tex_v) of the configured
// page and gives one result on res_o: the stored colour and its R5 G5 B5 A1
// repacking. cfg_i writes page_x, page_y, color_mode, clut_x and clut_y by
// index 0 to 4; it is always ready and must only be used while the block idles.
// Steps per item, set by the single-port memory: a write issues its memory write,
// a direct-colour fetch a texel read and a palette fetch a texel read, then a
// palette read, each with registered read data. The result is loaded in the done
// state once the output slot is free, and res_o.valid rises from its register.
// One item is worked on at a time.
// After reset the memory is cleared one halfword a cycle, all VRAM_WIDTH *
// VRAM_HEIGHT halfwords (524288 at the defaults); req_i stays not ready meanwhile.
// Results sit in an output register: a new item is taken while a result
// waits, and a finished fetch holds in place until res_o.ready frees the slot.
// depends on ctfd_pkg, ctfd_if, ctfd_ctrl and ctfd_datapath
module clut_texel_fetch_decode_unit #(
  parameter int VRAM_WIDTH  = 1024,
  parameter int VRAM_HEIGHT = 512,
  parameter int PAGE_SIZE   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctfd_req_if.sink   req_i,
  ctfd_res_if.source res_o,
  ctfd_cfg_if.sink   cfg_i
);
  import ctfd_pkg::*;

  ctfd_cmd_t cmd;
  ctfd_sts_t sts;

  assign cfg_i.ready = 1'b1;

  ctfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ctfd_datapath #(
    .VRAM_WIDTH  (VRAM_WIDTH),
    .VRAM_HEIGHT (VRAM_HEIGHT),
    .PAGE_SIZE   (PAGE_SIZE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .vram_x_i     (req_i.vram_x),
    .vram_y_i     (req_i.vram_y),
    .write_data_i (req_i.write_data),
    .tex_u_i      (req_i.tex_u),
    .tex_v_i      (req_i.tex_v),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .texel_raw_o  (res_o.texel_raw),
    .texel_rgba_o (res_o.texel_rgba)
  );

endmodule

// ===== sv/ctfd_ctrl.sv =====
// sequencer of the texel fetch block: clearing pass, write, texel and palette reads
// depends on ctfd_pkg and the assertion macro header
`include "clut_texel_fetch_decode_unit_macros.svh"

module ctfd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ctfd_pkg::ctfd_sts_t sts_i,
  output ctfd_pkg::ctfd_cmd_t cmd_o
);
  import ctfd_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_CLUT  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_write = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (!sts_i.is_fetch) begin
          cmd_o.mem_write = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.tex_read = 1'b1;
          state_d = sts_i.is_direct ? ST_DONE : ST_CLUT;
        end
      end
      ST_CLUT: begin
        cmd_o.clut_read = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `CTFD_ASSERT(a_no_overwrite, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result overwritten")
  `CTFD_ASSERT(a_port_exclusive, !((cmd_o.mem_write || cmd_o.clear_write) && (cmd_o.tex_read || cmd_o.clut_read)), "write and read collide")
  `CTFD_ASSERT(a_accept_issue, (in_valid_i && in_ready_o) |=> (state_q == ST_ISSUE), "accepted item not issued")
  `CTFD_ASSERT(a_clut_then_done, cmd_o.clut_read |=> (state_q == ST_DONE && !in_ready_o), "palette read not followed by result")
  `CTFD_ASSERT_ALWAYS(a_reset_blocks, !rst_ni |-> (!in_ready_o && !out_valid_o), "handshake open in reset")

endmodule

// ===== sv/ctfd_datapath.sv =====
// video memory, configuration registers, address arithmetic and result register
// depends on ctfd_pkg
module ctfd_datapath #(
  parameter int VRAM_WIDTH  = 1024,
  parameter int VRAM_HEIGHT = 512,
  parameter int PAGE_SIZE   = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ctfd_pkg::ctfd_cmd_t              cmd_i,
  output ctfd_pkg::ctfd_sts_t              sts_o,
  input  logic                             req_type_i,
  input  logic [ctfd_pkg::ReqXW-1:0]       vram_x_i,
  input  logic [ctfd_pkg::ReqYW-1:0]       vram_y_i,
  input  logic [ctfd_pkg::HalfW-1:0]       write_data_i,
  input  logic [ctfd_pkg::TexW-1:0]        tex_u_i,
  input  logic [ctfd_pkg::TexW-1:0]        tex_v_i,
  input  logic                             cfg_we_i,
  input  logic [ctfd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ctfd_pkg::CfgDataW-1:0]    cfg_data_i,
  output logic [ctfd_pkg::HalfW-1:0]       texel_raw_o,
  output logic [ctfd_pkg::HalfW-1:0]       texel_rgba_o
);
  import ctfd_pkg::*;

  localparam int MemWords = VRAM_WIDTH * VRAM_HEIGHT;
  localparam int AddrW    = $clog2(MemWords);
  localparam int SumW     = AddrW + 2;
  localparam int CoordW   = 14;
  localparam int UvW      = 10;
  localparam int ColW     = 11;
  localparam int LineW    = 9;

  // configuration
  logic [3:0] page_x_q;
  logic       page_y_q;
  logic [1:0] color_mode_q;
  logic [5:0] clut_x_q;
  logic [8:0] clut_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_x_q     <= '0;
      page_y_q     <= 1'b0;
      color_mode_q <= '0;
      clut_x_q     <= '0;
      clut_y_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PAGE_X:     page_x_q     <= cfg_data_i[3:0];
        CFG_PAGE_Y:     page_y_q     <= cfg_data_i[0];
        CFG_COLOR_MODE: color_mode_q <= cfg_data_i[1:0];
        CFG_CLUT_X:     clut_x_q     <= cfg_data_i[5:0];
        CFG_CLUT_Y:     clut_y_q     <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic              req_type_q;
  logic [ReqXW-1:0]  vram_x_q;
  logic [ReqYW-1:0]  vram_y_q;
  logic [HalfW-1:0]  write_data_q;
  logic [TexW-1:0]   tex_u_q;
  logic [TexW-1:0]   tex_v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      req_type_q   <= req_type_i;
      vram_x_q     <= vram_x_i;
      vram_y_q     <= vram_y_i;
      write_data_q <= write_data_i;
      tex_u_q      <= tex_u_i;
      tex_v_q      <= tex_v_i;
    end
  end

  // clearing pass counter
  logic [AddrW-1:0] clr_q, clr_d;
  logic             clear_last;

  assign clear_last = (clr_q == AddrW'(MemWords - 1));
  assign clr_d      = clear_last ? '0 : clr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_write) begin
      clr_q <= clr_d;
    end
  end

  // write address: coordinates wrap at the memory edges
  logic [CoordW-1:0] x_full, x_half, x_mod, y_full, y_mod;
  logic [SumW-1:0]   wr_sum;
  logic [AddrW-1:0]  wr_addr;

  always_comb begin
    x_full = CoordW'(vram_x_q);
    x_half = (x_full >= CoordW'(2 * VRAM_WIDTH)) ? x_full - CoordW'(2 * VRAM_WIDTH) : x_full;
    x_mod  = (x_half >= CoordW'(VRAM_WIDTH)) ? x_half - CoordW'(VRAM_WIDTH) : x_half;
    y_full = CoordW'(vram_y_q);
    y_mod  = (y_full >= CoordW'(VRAM_HEIGHT)) ? y_full - CoordW'(VRAM_HEIGHT) : y_full;
    wr_sum = SumW'(y_mod) * SumW'(VRAM_WIDTH) + SumW'(x_mod);
    wr_addr = wr_sum[AddrW-1:0];
  end

  // texel coordinates within the page
  logic [UvW-1:0]  u_full, u_half, u_mod, v_full, v_half, v_mod;
  logic [TexW-1:0] u8, v8;

  always_comb begin
    u_full = UvW'(tex_u_q);
    u_half = (u_full >= UvW'(2 * PAGE_SIZE)) ? u_full - UvW'(2 * PAGE_SIZE) : u_full;
    u_mod  = (u_half >= UvW'(PAGE_SIZE)) ? u_half - UvW'(PAGE_SIZE) : u_half;
    v_full = UvW'(tex_v_q);
    v_half = (v_full >= UvW'(2 * PAGE_SIZE)) ? v_full - UvW'(2 * PAGE_SIZE) : v_full;
    v_mod  = (v_half >= UvW'(PAGE_SIZE)) ? v_half - UvW'(PAGE_SIZE) : v_half;
    u8 = u_mod[TexW-1:0];
    v8 = v_mod[TexW-1:0];
  end

  // memory and its registered read data
  logic [HalfW-1:0] mem [MemWords];
  logic [HalfW-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, rd_addr;
  logic [HalfW-1:0] mem_wdata;

  // texel and palette addresses
  logic [LineW-1:0] tex_line, rd_line;
  logic [ColW-1:0]  tex_col, clut_col, rd_col, page_base;
  logic [7:0]       byte_v, clut_idx;
  logic             byte_sel;
  logic [SumW-1:0]  rd_sum, rd_part;

  always_comb begin
    tex_line  = {page_y_q, v8};
    page_base = ColW'({page_x_q, 6'b0});
    case (color_mode_q)
      MODE_CLUT4: tex_col = page_base + ColW'(u8[7:2]);
      MODE_CLUT8: tex_col = page_base + ColW'(u8[7:1]);
      default:    tex_col = page_base + ColW'(u8);
    endcase

    byte_sel = (color_mode_q == MODE_CLUT4) ? u8[1] : u8[0];
    byte_v   = byte_sel ? rdata_q[15:8] : rdata_q[7:0];
    if (color_mode_q == MODE_CLUT4) begin
      clut_idx = {4'b0, (u8[0] ? byte_v[7:4] : byte_v[3:0])};
    end else begin
      clut_idx = byte_v;
    end
    clut_col = ColW'({clut_x_q, 4'b0}) + ColW'(clut_idx);

    rd_line = cmd_i.clut_read ? clut_y_q : tex_line;
    rd_col  = cmd_i.clut_read ? clut_col : tex_col;

    // linear address runs past line ends and wraps at the memory size
    rd_sum  = SumW'(rd_line) * SumW'(VRAM_WIDTH) + SumW'(rd_col);
    rd_part = (rd_sum >= SumW'(2 * MemWords)) ? rd_sum - SumW'(2 * MemWords) : rd_sum;
    rd_addr = (rd_part >= SumW'(MemWords)) ? AddrW'(rd_part - SumW'(MemWords))
                                           : AddrW'(rd_part);
  end

  assign mem_we    = cmd_i.clear_write | cmd_i.mem_write;
  assign mem_re    = cmd_i.tex_read | cmd_i.clut_read;
  assign mem_waddr = cmd_i.clear_write ? clr_q : wr_addr;
  assign mem_wdata = cmd_i.clear_write ? '0 : write_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // result register
  logic [HalfW-1:0] raw_q, rgba_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      raw_q  <= rdata_q;
      rgba_q <= {rdata_q[4:0], rdata_q[9:5], rdata_q[14:10], rdata_q[15]};
    end
  end

  assign texel_raw_o  = raw_q;
  assign texel_rgba_o = rgba_q;

  assign sts_o.clear_last = clear_last;
  assign sts_o.is_fetch   = (req_type_q == REQ_FETCH);
  assign sts_o.is_direct  = (color_mode_q != MODE_CLUT4) && (color_mode_q != MODE_CLUT8);

endmodule
